// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the sampler.
// Depends on nothing; included by the top file, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/dics_pkg.sv =====
// Package of the discrete inverse-CDF sampler: sizes, item kind codes,
// generator constants and the controller/datapath command and status types.
// Depends on nothing.
package dics_pkg;

    // table geometry (rows must stay a power of two up to 64: rows wrap by truncation)
    localparam int NUM_ROWS     = 64;
    localparam int NUM_OUTCOMES = 16;
    localparam int MAX_RUN      = 16;
    localparam int VALUE_WIDTH  = 32;

    // port field widths
    localparam int ROW_W  = 6;
    localparam int OC_W   = 4;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int SEED_W = 31;

    localparam int ROW_IDX_W = $clog2(NUM_ROWS);
    localparam int OC_IDX_W  = $clog2(NUM_OUTCOMES);
    localparam int TBL_DEPTH = NUM_ROWS * NUM_OUTCOMES;
    localparam int TBL_AW    = ROW_IDX_W + OC_IDX_W;
    localparam int SUM_W     = SEED_W + OC_IDX_W;

    // item kinds
    localparam logic [1:0] KIND_WR_PROB  = 2'd0;
    localparam logic [1:0] KIND_WR_VAL   = 2'd1;
    localparam logic [1:0] KIND_DRAW_IND = 2'd2;
    localparam logic [1:0] KIND_DRAW_BLK = 2'd3;

    // Lehmer generator, modulus 2^31-1
    localparam int                MUL_W      = 15;
    localparam int                PROD_W     = SEED_W + MUL_W;
    localparam logic [MUL_W-1:0]  LEHMER_MUL = 15'd16807;
    localparam logic [SEED_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

    typedef struct packed {
        logic accept;
        logic wr_prob;
        logic wr_val;
        logic seed_mul;
        logic seed_mod;
        logic walk_start;
        logic walk_step;
        logic vread;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic run_last;
        logic out_free;
        logic is_block;
    } t_stat;

endpackage

// ===== src/dics_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dics_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dics_ctrl.sv =====
// Controller of the sampler: sequences seed update, outcome walk, value read
// and result hand-off. Depends on dics_pkg.
module dics_ctrl
    import dics_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    input  logic [CNT_W-1:0] i_count,
    input  t_stat            i_stat,
    output logic             o_in_ready,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_VREAD = 3'd4;
    localparam logic [2:0] S_VDATA = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_WR_PROB) begin
                        o_cmd.wr_prob = 1'b1;
                    end else if (i_kind == KIND_WR_VAL) begin
                        o_cmd.wr_val = 1'b1;
                    end else if ((i_kind inside {KIND_DRAW_IND, KIND_DRAW_BLK})
                                 && (i_count != '0)) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.seed_mul = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.seed_mod   = 1'b1;
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_VREAD;
                end
            end
            S_VREAD: begin
                o_cmd.vread = 1'b1;
                n_state     = S_VDATA;
            end
            S_VDATA: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.run_last) begin
                        n_state = S_IDLE;
                    end else if (i_stat.is_block) begin
                        n_state = S_VREAD;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dics_dp.sv =====
// Datapath of the sampler: Lehmer seed, both tables, running-sum walk and
// the output register. Depends on dics_pkg and dics_ram.
module dics_dp
    import dics_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_valid,
    input  logic [SEED_W-1:0]        i_cfg_seed_start,
    input  logic [1:0]               i_kind,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [OC_W-1:0]          i_outcome,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic [ROW_W-1:0]         i_first_var,
    input  logic [CNT_W-1:0]         i_count,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_W-1:0]         o_var_index,
    output logic signed [DATA_W-1:0] o_sample_value,
    output logic [OC_W-1:0]          o_chosen_outcome,
    output logic                     o_no_outcome,
    output logic                     o_last
);

    // latched item fields
    logic                 r_is_block;
    logic [ROW_IDX_W-1:0] r_row;
    logic [ROW_IDX_W-1:0] r_var;
    logic [CNT_W-1:0]     r_left;

    // generator
    logic [SEED_W-1:0] r_seed;
    logic [PROD_W-1:0] r_prod;
    logic [SEED_W:0]   red_sum;
    logic [SEED_W:0]   red_val;

    // walk
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    sum_n;
    logic [OC_IDX_W:0]   r_kiss;
    logic [OC_IDX_W-1:0] r_kdat;
    logic                r_rdv;
    logic                r_done;
    logic [OC_IDX_W-1:0] r_chosen;
    logic                r_missed;
    logic                issue;
    logic [ROW_IDX_W-1:0] walk_row;

    // tables
    logic                   prob_we;
    logic [SEED_W-1:0]      prob_wdata;
    logic [SEED_W-1:0]      prob_rdata;
    logic                   val_we;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic [TBL_AW-1:0]      wr_addr;

    // output stage
    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_o_var;
    logic signed [DATA_W-1:0] r_o_value;
    logic [OC_W-1:0]          r_o_chosen;
    logic                     r_o_missed;
    logic                     r_o_last;
    logic                     out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- table writes ----------------
    assign wr_addr    = {i_row[ROW_IDX_W-1:0], i_outcome[OC_IDX_W-1:0]};
    assign prob_we    = i_cmd.wr_prob && ({1'b0, i_outcome} < (OC_W + 1)'(NUM_OUTCOMES));
    assign val_we     = i_cmd.wr_val && ({1'b0, i_outcome} < (OC_W + 1)'(NUM_OUTCOMES));
    // negative probability stored as zero
    assign prob_wdata = i_data[DATA_W-1] ? '0 : i_data[SEED_W-1:0];

    assign walk_row = r_is_block ? r_row : r_var;
    assign issue    = i_cmd.walk_step && (r_kiss < (OC_IDX_W + 1)'(NUM_OUTCOMES));

    dics_ram #(
        .WIDTH (SEED_W),
        .DEPTH (TBL_DEPTH)
    ) u_prob_ram (
        .i_clk   (i_clk),
        .i_we    (prob_we),
        .i_waddr (wr_addr),
        .i_wdata (prob_wdata),
        .i_re    (issue),
        .i_raddr ({walk_row, r_kiss[OC_IDX_W-1:0]}),
        .o_rdata (prob_rdata)
    );

    dics_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TBL_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (wr_addr),
        .i_wdata (i_data[VALUE_WIDTH-1:0]),
        .i_re    (i_cmd.vread),
        .i_raddr ({r_var, r_chosen}),
        .o_rdata (val_rdata)
    );

    // ---------------- item fields ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_block <= (i_kind == KIND_DRAW_BLK);
            r_row      <= i_row[ROW_IDX_W-1:0];
            r_var      <= i_first_var[ROW_IDX_W-1:0];
            r_left     <= (i_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : i_count;
        end else if (i_cmd.out_load) begin
            r_var  <= (r_var == ROW_IDX_W'(NUM_ROWS - 1)) ? '0 : r_var + 1'b1;
            r_left <= r_left - 1'b1;
        end
    end

    // ---------------- generator ----------------
    // 2^31 == 1 mod M, so hi + lo is congruent and below 2M
    assign red_sum = (SEED_W + 1)'(r_prod[SEED_W-1:0])
                   + (SEED_W + 1)'(r_prod[PROD_W-1:SEED_W]);
    assign red_val = (red_sum >= {1'b0, LEHMER_MOD}) ? red_sum - {1'b0, LEHMER_MOD}
                                                      : red_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_seed_start;
        end else if (i_cmd.seed_mod) begin
            r_seed <= red_val[SEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_mul) begin
            r_prod <= PROD_W'(r_seed) * PROD_W'(LEHMER_MUL);
        end
    end

    // ---------------- outcome walk ----------------
    assign sum_n = r_sum + SUM_W'(prob_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kiss <= '0;
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_kiss <= '0;
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
            r_sum  <= '0;
        end else if (i_cmd.walk_step) begin
            r_kiss <= r_kiss + (OC_IDX_W + 1)'(issue);
            r_rdv  <= issue;
            r_kdat <= r_kiss[OC_IDX_W-1:0];
            if (r_rdv && !r_done) begin
                r_sum <= sum_n;
                if (sum_n >= SUM_W'(r_seed)) begin
                    r_done   <= 1'b1;
                    r_chosen <= r_kdat;
                    r_missed <= 1'b0;
                end else if (r_kdat == OC_IDX_W'(NUM_OUTCOMES - 1)) begin
                    r_done   <= 1'b1;
                    r_chosen <= r_kdat;
                    r_missed <= 1'b1;
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_var     <= ROW_W'(r_var);
            r_o_value   <= DATA_W'(signed'(val_rdata));
            r_o_chosen  <= OC_W'(r_chosen);
            r_o_missed  <= r_missed;
            r_o_last    <= (r_left == CNT_W'(1));
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_var_index      = r_o_var;
    assign o_sample_value   = r_o_value;
    assign o_chosen_outcome = r_o_chosen;
    assign o_no_outcome     = r_o_missed;
    assign o_last           = r_o_last;

    assign o_stat.walk_done = r_done;
    assign o_stat.run_last  = (r_left == CNT_W'(1));
    assign o_stat.out_free  = out_free;
    assign o_stat.is_block  = r_is_block;

endmodule

// ===== src/discrete_inverse_cdf_sampler.sv =====
// Discrete inverse-CDF sampler driven by a minimal-standard Lehmer generator.
// Input channel (i_in_valid/o_in_ready): one item per handshake. Kinds 0 and 1
//   write one probability or value entry and finish in the accept cycle.
//   Kind 2 (independent draw) advances the seed once per variable and walks that
//   variable's row; kind 3 (block draw) advances the seed once, walks i_row and
//   emits the chosen column's value for every variable of the run.
// Output channel (o_out_valid/i_out_ready): one result per variable, o_last on
//   the final one. A single output register separates the two sides; a stalled
//   receiver holds the current result and the run pauses at the value read.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): loads the seed.
// Sequence: a draw result passes through seed multiply and reduce, the
//   probability walk (one RAM read per outcome, the read being registered),
//   then value read and hand-off; each further block result repeats only the
//   value read and hand-off. The walk through the probability RAM port sets
//   the rate of independent results.
// A new item is taken once the last result of a run sits in the output register.
// Reset (synchronous, active low) sets the seed to 1 and clears control state;
// the tables are undefined until written.
// Depends on dics_pkg, dics_ctrl, dics_dp, dics_ram, assert_macros.svh.
`include "assert_macros.svh"

module discrete_inverse_cdf_sampler
    import dics_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SEED_W-1:0]        i_cfg_seed_start,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_kind,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [OC_W-1:0]          i_outcome,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic [ROW_W-1:0]         i_first_var,
    input  logic [CNT_W-1:0]         i_count,
    // results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_W-1:0]         o_var_index,
    output logic signed [DATA_W-1:0] o_sample_value,
    output logic [OC_W-1:0]          o_chosen_outcome,
    output logic                     o_no_outcome,
    output logic                     o_last
);

    t_cmd  cmd;
    t_stat stat;

    // seed register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    dics_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_count    (i_count),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    dics_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_seed_start (i_cfg_seed_start),
        .i_kind           (i_kind),
        .i_row            (i_row),
        .i_outcome        (i_outcome),
        .i_data           (i_data),
        .i_first_var      (i_first_var),
        .i_count          (i_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_var_index      (o_var_index),
        .o_sample_value   (o_sample_value),
        .o_chosen_outcome (o_chosen_outcome),
        .o_no_outcome     (o_no_outcome),
        .o_last           (o_last)
    );

    // a result is only loaded into a free output register
    `ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, cmd.out_load, stat.out_free, "result loaded over a pending one")
    // a draw with a nonzero count closes the input until its run is done
    `ASSERT_NEXT(a_draw_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind[1] && (i_count != '0), !o_in_ready, "input still open after draw accept")
    // the final result of a run reopens the input
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, cmd.out_load && stat.run_last, o_in_ready, "input not reopened after last result")

endmodule
